[rtl/core/assert_macros.svh]
// Assertion helpers used by ddfp_parse.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/ddfp_pkg.sv]
package ddfp_pkg;

  // field phases
  localparam logic [1:0] PH_WS    = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_DELIM  = 2'd0;
  localparam logic [1:0] CFG_UPDATE = 2'd1;
  localparam logic [1:0] CFG_ROUTE  = 2'd2;

  // character codes
  localparam logic [7:0] CH_TERM  = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

  typedef struct packed {
    logic [7:0]         delimiter;
    logic signed [31:0] update_code;
    logic               route_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_update;
    logic               last;
  } result_t;

endpackage

[rtl/core/ddfp_in_stage.sv]
module ddfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_in,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_char
);

  // hold the registered item until the parser takes it
  assign in_stall = item_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_char <= char_in;
    end
  end

endmodule

[rtl/core/ddfp_parse.sv]
`include "assert_macros.svh"

module ddfp_parse (
  input  logic              clk,
  input  logic              rst,
  input  ddfp_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  logic [7:0]        item_char,
  input  logic              out_free,
  output logic              take,
  output logic              res_valid,
  output ddfp_pkg::result_t res
);

  logic [1:0]  phase, phase_next;
  logic        negative, negative_next;
  logic [31:0] mag, mag_next;
  logic        first_field, first_field_next;
  logic        rec_upd, rec_upd_next;

  logic        is_end, is_term, is_digit, is_ws;
  logic [35:0] mag_ext;
  logic [31:0] fval;
  logic        upd_flag;

  // classify the character
  always_comb begin
    is_end   = (item_char == ddfp_pkg::CH_TERM);
    is_term  = is_end || (item_char == cfg.delimiter);
    is_digit = item_char inside {[ddfp_pkg::CH_ZERO:ddfp_pkg::CH_NINE]};
    is_ws    = (item_char == ddfp_pkg::CH_SPACE) ||
               (item_char inside {[ddfp_pkg::CH_TAB:ddfp_pkg::CH_CR]});
  end

  // a field end needs room in the output register
  assign take      = item_valid && (!is_term || out_free);
  assign res_valid = item_valid && is_term;

  // magnitude times ten plus the digit
  assign mag_ext = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} +
                   {32'd0, item_char[3:0] - ddfp_pkg::CH_ZERO[3:0]};

  // saturated signed value of the current field
  always_comb begin
    if (negative) begin
      fval = mag[31] ? ddfp_pkg::MAG_LIMIT : (32'd0 - mag);
    end else begin
      fval = mag[31] ? ddfp_pkg::POS_MAX : mag;
    end
  end

  assign upd_flag = first_field ?
                    (cfg.route_enable && (fval == cfg.update_code)) : rec_upd;

  assign res.value     = fval;
  assign res.is_update = upd_flag;
  assign res.last      = is_end;

  // next state
  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    mag_next         = mag;
    first_field_next = first_field;
    rec_upd_next     = rec_upd;
    if (is_term) begin
      phase_next    = ddfp_pkg::PH_WS;
      negative_next = 1'b0;
      mag_next      = 32'd0;
      if (is_end) begin
        first_field_next = 1'b1;
        rec_upd_next     = 1'b0;
      end else begin
        first_field_next = 1'b0;
        rec_upd_next     = upd_flag;
      end
    end else if (is_digit && phase != ddfp_pkg::PH_DONE) begin
      mag_next   = (mag_ext >= {4'd0, ddfp_pkg::MAG_LIMIT}) ?
                   ddfp_pkg::MAG_LIMIT : mag_ext[31:0];
      phase_next = ddfp_pkg::PH_DIGIT;
    end else if (phase == ddfp_pkg::PH_WS) begin
      if (item_char == ddfp_pkg::CH_PLUS || item_char == ddfp_pkg::CH_MINUS) begin
        negative_next = (item_char == ddfp_pkg::CH_MINUS);
        phase_next    = ddfp_pkg::PH_SIGN;
      end else if (!is_ws) begin
        phase_next = ddfp_pkg::PH_DONE;
      end
    end else begin
      phase_next = ddfp_pkg::PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ddfp_pkg::PH_WS;
      negative    <= 1'b0;
      mag         <= 32'd0;
      first_field <= 1'b1;
      rec_upd     <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      negative    <= negative_next;
      mag         <= mag_next;
      first_field <= first_field_next;
      rec_upd     <= rec_upd_next;
    end
  end

  `ASSERT_ALWAYS(a_mag_limit, clk, rst, mag <= ddfp_pkg::MAG_LIMIT, "magnitude above limit")
  `ASSERT_NEXT(a_rec_reset, clk, rst, take && is_end,
               first_field && !rec_upd && mag == 32'd0, "record state not cleared")
  `ASSERT_IMPL(a_hold_why, clk, rst, item_valid && !take,
               is_term && !out_free, "item held without cause")

endmodule

[rtl/core/ddfp_out_stage.sv]
module ddfp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ddfp_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] value,
  output logic              is_update,
  output logic              last
);

  // slot is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      value     <= res.value;
      is_update <= res.is_update;
      last      <= res.last;
    end
  end

endmodule

[rtl/core/delimited_decimal_field_parser_core.sv]
// channel | signals                          | direction
// input   | in_valid, in_stall, char_in      | item in, stall out
// output  | out_valid, out_stall, value,     | item out, stall in
//         | is_update, last                  |
// config  | cfg_wr, cfg_idx, cfg_data        | write only
// One character item per cycle while in_stall is low; a field value goes through the
// input register, then the result register, after its delimiter or terminator is accepted.
// The per-character step is one multiply-by-ten add with saturation.
// Synchronous reset clears the field state and loads register defaults.
// A held result stalls input only when the next item also ends a field.
module delimited_decimal_field_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic               is_update,
  output logic               last,
  input  logic               cfg_wr,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_data
);

  ddfp_pkg::cfg_t    cfg;
  ddfp_pkg::result_t res;
  logic              take, item_valid, res_valid, out_free;
  logic [7:0]        item_char;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter    <= 8'd44;
      cfg.update_code  <= 32'sd0;
      cfg.route_enable <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ddfp_pkg::CFG_DELIM:  cfg.delimiter    <= cfg_data[7:0];
        ddfp_pkg::CFG_UPDATE: cfg.update_code  <= cfg_data;
        ddfp_pkg::CFG_ROUTE:  cfg.route_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ddfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .take       (take),
    .item_valid (item_valid),
    .item_char  (item_char)
  );

  ddfp_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_char  (item_char),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  ddfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid && take),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .is_update (is_update),
    .last      (last)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Tracks the parser's field state and queues the field results it should emit.
class parsed_field_tracker;
  logic [7:0]         delim;
  logic signed [31:0] upd_code;
  logic               route_on;
  logic [1:0]         phase;
  logic               neg;
  logic [31:0]        mag;
  logic               first;
  logic               rec_upd;
  ddfp_pkg::result_t  expected_fields[$];
  int unsigned        failures;

  function new();
    delim    = 8'd44;
    upd_code = '0;
    route_on = 1'b1;
    phase    = ddfp_pkg::PH_WS;
    neg      = 1'b0;
    mag      = '0;
    first    = 1'b1;
    rec_upd  = 1'b0;
    failures = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      ddfp_pkg::CFG_DELIM:  delim = data[7:0];
      ddfp_pkg::CFG_UPDATE: upd_code = data;
      ddfp_pkg::CFG_ROUTE:  route_on = data[0];
      default: ;
    endcase
  endfunction

  // one accepted character
  function void note_char(logic [7:0] c);
    logic [31:0]       v;
    logic [35:0]       grown;
    ddfp_pkg::result_t r;
    if (c == ddfp_pkg::CH_TERM || c == delim) begin
      if (neg) v = (mag >= ddfp_pkg::MAG_LIMIT) ? ddfp_pkg::MAG_LIMIT : (32'd0 - mag);
      else v = (mag >= ddfp_pkg::MAG_LIMIT) ? ddfp_pkg::POS_MAX : mag;
      // routing is decided on the record's first field only
      if (first) begin
        rec_upd = route_on && (v == upd_code);
        first = 1'b0;
      end
      r.value = v;
      r.is_update = rec_upd;
      r.last = (c == ddfp_pkg::CH_TERM);
      expected_fields.push_back(r);
      phase = ddfp_pkg::PH_WS;
      neg = 1'b0;
      mag = '0;
      if (c == ddfp_pkg::CH_TERM) begin
        first = 1'b1;
        rec_upd = 1'b0;
      end
    end else if (c >= ddfp_pkg::CH_ZERO && c <= ddfp_pkg::CH_NINE &&
                 phase != ddfp_pkg::PH_DONE) begin
      grown = {4'd0, mag} * 36'd10 + 36'(c - ddfp_pkg::CH_ZERO);
      mag = (grown >= 36'(ddfp_pkg::MAG_LIMIT)) ? ddfp_pkg::MAG_LIMIT : grown[31:0];
      phase = ddfp_pkg::PH_DIGIT;
    end else if (phase == ddfp_pkg::PH_WS) begin
      if (c == ddfp_pkg::CH_PLUS || c == ddfp_pkg::CH_MINUS) begin
        neg = (c == ddfp_pkg::CH_MINUS);
        phase = ddfp_pkg::PH_SIGN;
      end else if (!(c == ddfp_pkg::CH_SPACE ||
                     (c >= ddfp_pkg::CH_TAB && c <= ddfp_pkg::CH_CR))) begin
        phase = ddfp_pkg::PH_DONE;
      end
    end else begin
      phase = ddfp_pkg::PH_DONE;
    end
  endfunction

  // one accepted result against the oldest expectation
  function void check_field(logic signed [31:0] v, logic u, logic l);
    ddfp_pkg::result_t want;
    if (expected_fields.size() == 0) begin
      $error("unexpected field result: value=%0d is_update=%0b last=%0b", v, u, l);
      failures++;
      return;
    end
    want = expected_fields.pop_front();
    if (v !== want.value) begin
      $error("value: expected %0d, got %0d", want.value, v);
      failures++;
    end
    if (u !== want.is_update) begin
      $error("is_update: expected %0b, got %0b", want.is_update, u);
      failures++;
    end
    if (l !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, l);
      failures++;
    end
  endfunction
endclass

module testbench;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_CHARS = 170;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         char_in;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] value;
  logic               is_update;
  logic               last;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic [31:0]        cfg_data;

  parsed_field_tracker tracker = new();

  // sender pacing and receiver stall controls
  int                 max_gap = 0;
  int                 burst_left = 0;
  int                 stall_style = 0;
  int                 hold_asks = 0;
  int                 holds_taken = 0;
  int                 hold_count = 0;
  logic [4:0]         stall_tick = '0;
  int                 idle_cycles = 0;
  int unsigned        chars_sent = 0;
  logic [7:0]         cur_delim = 8'd44;
  logic signed [31:0] cur_code = '0;

  delimited_decimal_field_parser_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .is_update (is_update),
    .last      (last),
    .cfg_wr    (cfg_wr),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver: long hold on request, otherwise the current stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_count <= 0;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      out_stall <= 1'b1;
    end else if (hold_asks != holds_taken) begin
      holds_taken <= hold_asks;
      hold_count <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      stall_tick <= stall_tick + 5'd1;
      case (stall_style)
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        3: out_stall <= (stall_tick[4:3] == 2'b11);
        4: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_field(value, is_update, last);
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // offer one character, with burst gaps when enabled
  task offer_char(input logic [7:0] c);
    if (max_gap != 0) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, max_gap)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b1;
    char_in <= c;
    do @(posedge clk); while (in_stall);
    tracker.note_char(c);
    chars_sent++;
  endtask

  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer_char(s[i]);
  endtask

  // stop sending until every expected field has come out, then let the pipe settle
  task drain();
    in_valid <= 1'b0;
    while (tracker.expected_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task load_settings(input logic [7:0] d, input logic signed [31:0] code, input logic route);
    cfg_wr <= 1'b1;
    cfg_idx <= ddfp_pkg::CFG_DELIM;
    cfg_data <= {24'd0, d};
    @(posedge clk);
    cfg_idx <= ddfp_pkg::CFG_UPDATE;
    cfg_data <= code;
    @(posedge clk);
    cfg_idx <= ddfp_pkg::CFG_ROUTE;
    cfg_data <= {31'd0, route};
    @(posedge clk);
    cfg_wr <= 1'b0;
    tracker.set_reg(ddfp_pkg::CFG_DELIM, {24'd0, d});
    tracker.set_reg(ddfp_pkg::CFG_UPDATE, code);
    tracker.set_reg(ddfp_pkg::CFG_ROUTE, {31'd0, route});
    cur_delim = d;
    cur_code = code;
  endtask

  // one random record: mostly well-formed numeric fields, some noise
  task emit_record();
    int    nfields;
    int    ndigits;
    string code_text;
    nfields = $urandom_range(1, 5);
    for (int f = 0; f < nfields; f++) begin
      if (f == 0 && $urandom_range(0, 2) == 0) begin
        // first value matching the update code
        code_text = $sformatf("%0d", cur_code);
        send_text(code_text);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) offer_char(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 5) == 0) offer_char(ddfp_pkg::CH_SPACE);
          else offer_char(ddfp_pkg::CH_TAB + 8'($urandom_range(0, 4)));
        end
        case ($urandom_range(0, 5))
          0: offer_char(ddfp_pkg::CH_MINUS);
          1: offer_char(ddfp_pkg::CH_PLUS);
          default: ;
        endcase
        case ($urandom_range(0, 7))
          0: ndigits = 0;
          1: ndigits = $urandom_range(9, 12);
          default: ndigits = $urandom_range(1, 4);
        endcase
        repeat (ndigits) offer_char(ddfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0) begin
          offer_char(8'($urandom_range(33, 126)));
          repeat ($urandom_range(0, 2))
            offer_char(ddfp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
      end
      if (f != nfields - 1) offer_char(cur_delim);
    end
    offer_char(ddfp_pkg::CH_TERM);
  endtask

  initial begin
    logic [7:0]         d;
    logic signed [31:0] code;
    logic               route;
    rst <= 1'b1;
    in_valid <= 1'b0;
    char_in <= '0;
    cfg_wr <= 1'b0;
    cfg_idx <= ddfp_pkg::CFG_DELIM;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, update record, negative overflow,
    // trailing junk, non-numeric and empty fields, high bytes
    stall_style = 2;
    send_text("\015+0,-3000000000");
    offer_char(ddfp_pkg::CH_TERM);
    send_text("9x1,\377-5,");
    offer_char(ddfp_pkg::CH_TERM);

    // random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin d = 8'd44;  code = 0;             route = 1'b1; max_gap = 6;  stall_style = 1; end
        1: begin d = 8'd59;  code = 7;             route = 1'b1; max_gap = 0;  stall_style = 1; end
        2: begin
          d = ddfp_pkg::CH_TERM; code = 32'h8000_0000; route = 1'b1;
          max_gap = 3; stall_style = 3;
        end
        3: begin d = 8'd255; code = 32'h7fff_ffff; route = 1'b0; max_gap = 10; stall_style = 2; end
        4: begin d = 8'h35;  code = -12;           route = 1'b1; max_gap = 0;  stall_style = 0; end
        default: begin
          d = 8'($urandom_range(1, 255));
          code = int'($urandom_range(0, 40)) - 20;
          route = 1'($urandom_range(0, 1));
          max_gap = 16;
          stall_style = 4;
        end
      endcase
      load_settings(d, code, route);
      // receiver holds off while the sender keeps going, filling the block
      if (p == 1) hold_asks++;
      chars_sent = 0;
      while (chars_sent < PHASE_CHARS) emit_record();
    end

    drain();
    if (tracker.failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ddfp_pkg.sv
rtl/core/ddfp_in_stage.sv
rtl/core/ddfp_parse.sv
rtl/core/ddfp_out_stage.sv
rtl/core/delimited_decimal_field_parser_core.sv
bench/testbench.sv
